// ----- rtl/icc_pkg.sv -----
package icc_pkg;

  localparam int MAX_WIDTH = 4096;

  localparam int PIX_W    = 32;
  localparam int COL_W    = 12;
  localparam int RATIO_W  = 17;
  localparam int RWIDTH_W = 13;
  localparam int CFG_W    = 17;
  localparam int IDX_W    = 2;
  localparam int RGB_W    = 24;
  localparam int INV_W    = 24;
  localparam int PROD_W   = RATIO_W + RWIDTH_W;

  localparam logic [RATIO_W-1:0]  Q_ONE      = 17'h10000;
  localparam logic [RATIO_W-1:0]  RATIO_INIT = 17'h08000;
  localparam logic [RWIDTH_W-1:0] WIDTH_CAP  = RWIDTH_W'(MAX_WIDTH);
  localparam logic [PIX_W-1:0]    RGB_MASK   = 32'h00FFFFFF;
  localparam logic [PIX_W-1:0]    INV_NUM    = 32'h00FF00FF;
  localparam logic [PIX_W-1:0]    ROUND_HALF = 32'h00008000;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE        = 2'd0,
    REG_RATIO       = 2'd1,
    REG_RIGHT_WIDTH = 2'd2
  } reg_index_t;

  typedef enum logic {
    MODE_SLIDING = 1'b0,
    MODE_ONION   = 1'b1
  } mode_t;

  // load enables of the two unpremultiply stages
  typedef struct packed {
    logic lookup;
    logic scale;
  } unpremul_en_t;

endpackage

// ----- rtl/icc_if.sv -----
interface icc_in_if;
  logic                         valid;
  logic                         ready;
  logic [icc_pkg::PIX_W-1:0]    left_pixel;
  logic [icc_pkg::PIX_W-1:0]    right_pixel;
  logic [icc_pkg::COL_W-1:0]    column;
  logic                         left_present;
  logic                         right_present;

  modport source (output valid, input ready, output left_pixel, output right_pixel,
                  output column, output left_present, output right_present);
  modport sink (input valid, output ready, input left_pixel, input right_pixel,
                input column, input left_present, input right_present);
endinterface

interface icc_out_if;
  logic                         valid;
  logic                         ready;
  logic [icc_pkg::PIX_W-1:0]    out_pixel;
  logic                         out_premultiplied;

  modport source (output valid, input ready, output out_pixel, output out_premultiplied);
  modport sink (input valid, output ready, input out_pixel, input out_premultiplied);
endinterface

// ----- rtl/icc_unpremul.sv -----
module icc_unpremul (
  input  logic                         clk,
  input  logic [icc_pkg::PIX_W-1:0]    pixel,
  input  icc_pkg::unpremul_en_t        en,
  output logic [icc_pkg::RGB_W-1:0]    rgb
);

  logic [icc_pkg::INV_W-1:0] inv_rom [256];

  // reciprocal of alpha, 0x00FF00FF / alpha, worked out at elaboration
  for (genvar i = 0; i < 256; i++) begin : g_inv
    localparam logic [icc_pkg::PIX_W-1:0] INV_VAL =
      (i == 0) ? 32'd0 : icc_pkg::INV_NUM / 32'((i == 0) ? 1 : i);
    assign inv_rom[i] = INV_VAL[icc_pkg::INV_W-1:0];
  end

  logic [icc_pkg::PIX_W-1:0] pix_a;
  logic [icc_pkg::INV_W-1:0] inv_a;

  always_ff @(posedge clk) begin
    if (en.lookup) begin
      pix_a <= pixel;
      inv_a <= inv_rom[pixel[31:24]];
    end
  end

  logic [icc_pkg::PIX_W-1:0] prod [3];
  logic [icc_pkg::RGB_W-1:0] scaled;
  logic [icc_pkg::PIX_W-1:0] kept;
  logic [icc_pkg::RGB_W-1:0] rgb_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = {24'd0, pix_a[8*k +: 8]} * {8'd0, inv_a} + icc_pkg::ROUND_HALF;
      scaled[8*k +: 8] = prod[k][23:16];
    end
    kept = pix_a & icc_pkg::RGB_MASK;
    if (pix_a[31:24] == 8'hFF) begin
      rgb_next = kept[icc_pkg::RGB_W-1:0];
    end else if (pix_a[31:24] == 8'h00) begin
      rgb_next = '0;
    end else begin
      rgb_next = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (en.scale) begin
      rgb <= rgb_next;
    end
  end

endmodule

// ----- rtl/image_compare_compositor_top.sv -----
// Channel   Role    Payload
// in_ch     sink    left_pixel, right_pixel, column, left_present, right_present
// out_ch    source  out_pixel, out_premultiplied
// wr_*      write   wr_index selects mode / ratio / right_width, wr_data is the value
//
// Four register stages: input capture, reciprocal lookup and split product,
// unpremultiply scaling and split compare, crossfade and final select.
// One pixel per cycle is sustained while out_ch is ready.
// Reset clears stage valid bits and loads the register reset values.
// Each stage holds while the one after it is full and stalled; bubbles still fill.
module image_compare_compositor_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [icc_pkg::IDX_W-1:0]     wr_index,
  input  logic [icc_pkg::CFG_W-1:0]     wr_data,
  icc_in_if.sink                        in_ch,
  icc_out_if.source                     out_ch
);

  // configuration
  icc_pkg::mode_t                 mode;
  logic [icc_pkg::RATIO_W-1:0]    ratio;
  logic [icc_pkg::RWIDTH_W-1:0]   right_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= icc_pkg::MODE_SLIDING;
      ratio       <= icc_pkg::RATIO_INIT;
      right_width <= '0;
    end else if (wr_en) begin
      case (wr_index)
        icc_pkg::REG_MODE:        mode        <= icc_pkg::mode_t'(wr_data[0]);
        icc_pkg::REG_RATIO:       ratio       <= wr_data;
        icc_pkg::REG_RIGHT_WIDTH: right_width <= wr_data[icc_pkg::RWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  logic [icc_pkg::RATIO_W-1:0]  q;
  logic [icc_pkg::RATIO_W-1:0]  q_inv;
  logic [icc_pkg::RWIDTH_W-1:0] w;

  assign q     = (ratio > icc_pkg::Q_ONE) ? icc_pkg::Q_ONE : ratio;
  assign q_inv = icc_pkg::Q_ONE - q;
  assign w     = (right_width > icc_pkg::WIDTH_CAP) ? icc_pkg::WIDTH_CAP : right_width;

  // stage handshake
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4 || out_ch.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_ch.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // stage 1: capture
  logic [icc_pkg::PIX_W-1:0] l1, r1;
  logic [icc_pkg::COL_W-1:0] col1;
  logic                      lp1, rp1;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      l1   <= in_ch.left_pixel;
      r1   <= in_ch.right_pixel;
      col1 <= in_ch.column;
      lp1  <= in_ch.left_present;
      rp1  <= in_ch.right_present;
    end
  end

  // stage 2: split product
  logic [icc_pkg::PIX_W-1:0]  l2, r2;
  logic [icc_pkg::COL_W-1:0]  col2;
  logic                       lp2, rp2;
  logic [icc_pkg::PROD_W-1:0] split_prod;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      l2         <= l1;
      r2         <= r1;
      col2       <= col1;
      lp2        <= lp1;
      rp2        <= rp1;
      split_prod <= icc_pkg::PROD_W'(q) * icc_pkg::PROD_W'(w);
    end
  end

  // stage 3: split compare; unpremultiplied colors come from the submodules
  icc_pkg::unpremul_en_t upm_en;
  logic [icc_pkg::RGB_W-1:0] lc3, rc3;

  assign upm_en.lookup = rdy2;
  assign upm_en.scale  = rdy3;

  icc_unpremul u_unpremul_left (
    .clk   (clk),
    .pixel (l1),
    .en    (upm_en),
    .rgb   (lc3)
  );

  icc_unpremul u_unpremul_right (
    .clk   (clk),
    .pixel (r1),
    .en    (upm_en),
    .rgb   (rc3)
  );

  logic [icc_pkg::PROD_W:0]     split_sum;
  logic [icc_pkg::RWIDTH_W-1:0] split;
  logic                         below_split, below_width;

  assign split_sum   = {1'b0, split_prod} + (icc_pkg::PROD_W+1)'(32768);
  assign split       = split_sum[icc_pkg::RWIDTH_W+15:16];
  assign below_split = {1'b0, col2} < split;
  assign below_width = {1'b0, col2} < w;

  logic [icc_pkg::PIX_W-1:0] l3, r3;
  logic                      lp3, rp3;
  logic                      wipe_right, wipe_left;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      l3         <= l2;
      r3         <= r2;
      lp3        <= lp2;
      rp3        <= rp2;
      wipe_right <= rp2 && below_split;
      wipe_left  <= rp2 && lp2 && !below_split && below_width;
    end
  end

  // stage 4: crossfade and select
  logic [24:0]               mix_sum [3];
  logic [icc_pkg::RGB_W-1:0] blend;
  logic [icc_pkg::PIX_W-1:0] pix_next;
  logic                      pm_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mix_sum[k] = 25'(q) * 25'(rc3[8*k +: 8]) + 25'(q_inv) * 25'(lc3[8*k +: 8]);
      blend[8*k +: 8] = mix_sum[k][23:16];
    end
    pix_next = '0;
    pm_next  = 1'b1;
    if (q == '0) begin
      if (lp3) pix_next = l3;
    end else if (q == icc_pkg::Q_ONE) begin
      if (rp3) pix_next = r3;
    end else if (mode == icc_pkg::MODE_SLIDING) begin
      if (wipe_right) begin
        pix_next = r3;
      end else if (wipe_left) begin
        pix_next = l3;
      end
    end else begin
      pm_next = 1'b0;
      if (lp3 && rp3) pix_next = {l3[31:24], blend};
    end
  end

  logic [icc_pkg::PIX_W-1:0] pix4;
  logic                      pm4;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      pix4 <= pix_next;
      pm4  <= pm_next;
    end
  end

  assign out_ch.valid             = v4;
  assign out_ch.out_pixel         = pix4;
  assign out_ch.out_premultiplied = pm4;

endmodule

// ----- rtl/icc_checker.sv -----
module icc_protocol_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [icc_pkg::PIX_W-1:0] out_pixel,
  input logic                      out_premultiplied
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_pixel) && $stable(out_premultiplied))
    else $error("output payload changed while stalled");

  a_no_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled with output side free");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready
    |=> out_valid)
    else $error("pixel did not arrive after four cycles");

endmodule

bind image_compare_compositor_top icc_protocol_checker u_icc_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_pixel         (out_ch.out_pixel),
  .out_premultiplied (out_ch.out_premultiplied)
);

// ----- dv/icc_checker.sv -----
module icc_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [icc_pkg::IDX_W-1:0] wr_index,
  input  logic [icc_pkg::CFG_W-1:0] wr_data,
  icc_in_if                         in_ch,
  icc_out_if                        out_ch,
  output int                        mismatches,
  output int                        outstanding,
  output int                        pixels_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import icc_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             pm;
  } composite_t;

  mode_t               cfg_mode;
  logic [RATIO_W-1:0]  cfg_ratio;
  logic [RWIDTH_W-1:0] cfg_width;
  composite_t          expected_pixels[$];

  function automatic logic [PIX_W-1:0] unpremultiply(input logic [PIX_W-1:0] p);
    logic [7:0]       a;
    logic [31:0]      inv;
    logic [63:0]      prod;
    logic [PIX_W-1:0] res;
    int               k;
    a = p[31:24];
    if (a == 8'hFF) return p;
    if (a == 8'h00) return '0;
    inv = INV_NUM / {24'd0, a};
    res = {a, 24'd0};
    for (k = 0; k < 3; k++) begin
      prod = 64'(p[8*k +: 8]) * 64'(inv) + 64'(ROUND_HALF);
      res[8*k +: 8] = prod[23:16];
    end
    return res;
  endfunction

  // truncating Q16 crossfade of one channel
  function automatic logic [7:0] crossfade(input logic [7:0] rc, input logic [7:0] lc,
                                           input logic [RATIO_W-1:0] q);
    logic [63:0] v;
    v = 64'(q) * 64'(rc) + (64'(Q_ONE) - 64'(q)) * 64'(lc);
    return v[23:16];
  endfunction

  function automatic composite_t composite_pixel(
    input logic [PIX_W-1:0]    lp,
    input logic [PIX_W-1:0]    rp,
    input logic [COL_W-1:0]    col,
    input logic                lpres,
    input logic                rpres,
    input mode_t               mode,
    input logic [RATIO_W-1:0]  ratio,
    input logic [RWIDTH_W-1:0] width
  );
    logic [RATIO_W-1:0]  q;
    logic [RWIDTH_W-1:0] w;
    logic [31:0]         split;
    logic [PIX_W-1:0]    lu;
    logic [PIX_W-1:0]    ru;
    composite_t          res;
    q = (ratio > Q_ONE) ? Q_ONE : ratio;
    res.pix = '0;
    res.pm = 1'b1;
    if (q == '0) begin
      res.pix = lpres ? lp : '0;
    end else if (q == Q_ONE) begin
      res.pix = rpres ? rp : '0;
    end else if (mode == MODE_SLIDING) begin
      w = (width > WIDTH_CAP) ? WIDTH_CAP : width;
      split = 32'((64'(q) * 64'(w) + 64'h8000) >> 16);
      if (rpres && {20'd0, col} < split)
        res.pix = rp;
      else if (rpres && lpres && {20'd0, col} >= split && {20'd0, col} < {19'd0, w})
        res.pix = lp;
    end else begin
      res.pm = 1'b0;
      if (lpres && rpres) begin
        lu = unpremultiply(lp) & RGB_MASK;
        ru = unpremultiply(rp) & RGB_MASK;
        res.pix = {lp[31:24], crossfade(ru[23:16], lu[23:16], q),
                   crossfade(ru[15:8], lu[15:8], q), crossfade(ru[7:0], lu[7:0], q)};
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    composite_t want;
    if (rst) begin
      cfg_mode = MODE_SLIDING;
      cfg_ratio = RATIO_INIT;
      cfg_width = '0;
      expected_pixels.delete();
      mismatches = 0;
      pixels_checked = 0;
    end else begin
      if (wr_en) begin
        case (reg_index_t'(wr_index))
          REG_MODE:        cfg_mode = mode_t'(wr_data[0]);
          REG_RATIO:       cfg_ratio = wr_data[RATIO_W-1:0];
          REG_RIGHT_WIDTH: cfg_width = wr_data[RWIDTH_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_pixels.push_back(composite_pixel(in_ch.left_pixel, in_ch.right_pixel,
                                                  in_ch.column, in_ch.left_present,
                                                  in_ch.right_present, cfg_mode,
                                                  cfg_ratio, cfg_width));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: pixel %h premultiplied %b", $realtime,
                     out_ch.out_pixel, out_ch.out_premultiplied);
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked++;
          if (out_ch.out_pixel !== want.pix || out_ch.out_premultiplied !== want.pm) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: pixel exp %h got %h, premultiplied exp %b got %b",
                       $realtime, want.pix, out_ch.out_pixel, want.pm,
                       out_ch.out_premultiplied);
          end
        end
      end
    end
    outstanding <= expected_pixels.size();
  end

endmodule

// ----- dv/tb_image_compare_compositor_top.sv -----
module tb_image_compare_compositor_top;
  timeunit 1ns;
  timeprecision 1ps;

  import icc_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int TAIL_CYCLES  = 20;

  logic                clk = 1'b0;
  logic                rst;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_index;
  logic [CFG_W-1:0]    wr_data;

  bit                  src_idle_on;
  bit                  sink_idle_on;
  bit                  hold_req;
  int                  items_sent = 0;
  int                  settings_applied = 0;
  int                  cycles = 0;
  logic [RATIO_W-1:0]  cur_ratio;
  logic [RWIDTH_W-1:0] cur_width;

  int                  mismatches;
  int                  outstanding;
  int                  pixels_checked;

  icc_in_if  in_ch ();
  icc_out_if out_ch ();

  image_compare_compositor_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  icc_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .pixels_checked (pixels_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [7:0]       a;
    logic [PIX_W-1:0] p;
    p = $urandom();
    a = p[31:24];
    case ($urandom_range(0, 7))
      0:       p[31:24] = 8'h00;
      1:       p[31:24] = 8'hFF;
      2:       p = '0;
      3:       p = '1;
      4, 5:    p = {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
                    8'($urandom_range(0, a))};
      default: ;
    endcase
    return p;
  endfunction

  // bias columns toward the split and the right image edge
  function automatic logic [COL_W-1:0] rand_column(input logic [RATIO_W-1:0] r,
                                                   input logic [RWIDTH_W-1:0] w);
    int q;
    int wc;
    int split;
    int c;
    q = (r > Q_ONE) ? int'(Q_ONE) : int'(r);
    wc = (w > WIDTH_CAP) ? int'(WIDTH_CAP) : int'(w);
    split = int'((longint'(q) * longint'(wc) + 32768) >>> 16);
    case ($urandom_range(0, 3))
      0:       c = int'($urandom_range(0, 4095));
      1:       c = split + int'($urandom_range(0, 4)) - 2;
      2:       c = wc + int'($urandom_range(0, 4)) - 2;
      default: c = int'($urandom_range(0, (wc + 8 > 4095) ? 4095 : wc + 8));
    endcase
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return COL_W'(c);
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] lp, input logic [PIX_W-1:0] rp,
                            input logic [COL_W-1:0] col, input logic lpres,
                            input logic rpres);
    int gap;
    gap = src_idle_on ? int'($urandom_range(0, 5)) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.left_pixel    <= lp;
    in_ch.right_pixel   <= rp;
    in_ch.column        <= col;
    in_ch.left_present  <= lpres;
    in_ch.right_present <= rpres;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // registers change only once the pipeline has drained
  task automatic apply_settings(input mode_t m, input logic [RATIO_W-1:0] r,
                                input logic [RWIDTH_W-1:0] w);
    wait_for_results();
    wr_en    <= 1'b1;
    wr_index <= REG_MODE;
    wr_data  <= CFG_W'(m);
    @(posedge clk);
    wr_index <= REG_RATIO;
    wr_data  <= CFG_W'(r);
    @(posedge clk);
    wr_index <= REG_RIGHT_WIDTH;
    wr_data  <= CFG_W'(w);
    @(posedge clk);
    wr_en <= 1'b0;
    cur_ratio = r;
    cur_width = w;
    settings_applied++;
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = sink_idle_on ? int'($urandom_range(0, 5)) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    mode_t               m;
    logic [RATIO_W-1:0]  r;
    logic [RWIDTH_W-1:0] w;
    logic                lpres;
    logic                rpres;
    int                  phase;
    int                  phase_len;
    int                  random_sent;
    int                  sel;

    rst                 <= 1'b1;
    wr_en               <= 1'b0;
    wr_index            <= REG_MODE;
    wr_data             <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.left_pixel    <= '0;
    in_ch.right_pixel   <= '0;
    in_ch.column        <= '0;
    in_ch.left_present  <= 1'b0;
    in_ch.right_present <= 1'b0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    hold_req     = 1'b0;
    cur_ratio    = RATIO_INIT;
    cur_width    = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset registers: zero right width leaves the wipe empty
    send_pixel(32'hFFFFFFFF, 32'h80402010, 12'd0, 1'b1, 1'b1);
    send_pixel(32'h12345678, 32'hFFFFFFFF, 12'd4095, 1'b1, 1'b1);

    // half ratio over 16 columns puts the split at column 8
    apply_settings(MODE_SLIDING, 17'd32768, 13'd16);
    send_pixel(32'hC0604020, 32'h80402010, 12'd7, 1'b1, 1'b1);
    send_pixel(32'hC0604020, 32'h80402010, 12'd8, 1'b1, 1'b1);
    send_pixel(32'hC0604020, 32'h80402010, 12'd8, 1'b0, 1'b1);
    send_pixel(32'hC0604020, 32'h80402010, 12'd15, 1'b1, 1'b1);
    send_pixel(32'hC0604020, 32'h80402010, 12'd16, 1'b1, 1'b1);
    send_pixel(32'hC0604020, 32'h80402010, 12'd0, 1'b1, 1'b0);

    // zero ratio passes the left pixel even in onion mode
    apply_settings(MODE_ONION, 17'd0, 13'd100);
    send_pixel(32'hFFFFFFFF, 32'h00000000, 12'd5, 1'b1, 1'b0);
    send_pixel(32'hFFFFFFFF, 32'h00000000, 12'd5, 1'b0, 1'b1);

    apply_settings(MODE_SLIDING, Q_ONE, 13'd100);
    send_pixel(32'h00000000, 32'hFFFFFFFF, 12'd4095, 1'b0, 1'b1);
    send_pixel(32'h00000000, 32'hFFFFFFFF, 12'd4095, 1'b1, 1'b0);

    // onion: opaque, transparent and half-alpha unpremultiply, left absent
    apply_settings(MODE_ONION, 17'd16384, 13'd0);
    send_pixel(32'hFF102030, 32'hFFF0E0D0, 12'd1, 1'b1, 1'b1);
    send_pixel(32'h00FFFFFF, 32'h80402010, 12'd2, 1'b1, 1'b1);
    send_pixel(32'h80804020, 32'h00000000, 12'd3, 1'b1, 1'b1);
    send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 12'd4095, 1'b1, 1'b1);
    send_pixel(32'h80804020, 32'h80402010, 12'd3, 1'b0, 1'b1);

    // ratio above one saturates, width above the cap saturates
    apply_settings(MODE_SLIDING, 17'h1FFFF, 13'h1FFF);
    send_pixel(32'h11223344, 32'h55667788, 12'd4095, 1'b1, 1'b1);
    send_pixel(32'h11223344, 32'h55667788, 12'd0, 1'b1, 1'b0);

    // smallest ratio over a capped width rounds the split to zero
    apply_settings(MODE_SLIDING, 17'd1, 13'h1FFF);
    send_pixel(32'hA0A0A0A0, 32'h50505050, 12'd0, 1'b1, 1'b1);
    send_pixel(32'hA0A0A0A0, 32'h50505050, 12'd4095, 1'b1, 1'b1);

    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      m = mode_t'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       r = '0;
        1:       r = Q_ONE;
        2:       r = 17'd1;
        3:       r = 17'd65535;
        4:       r = RATIO_W'($urandom_range(65537, 131071));
        default: r = RATIO_W'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 7))
        0:       w = '0;
        1:       w = WIDTH_CAP;
        2:       w = RWIDTH_W'($urandom_range(4097, 8191));
        3:       w = 13'd1;
        4, 5:    w = RWIDTH_W'($urandom_range(1, 64));
        default: w = RWIDTH_W'($urandom_range(0, 4096));
      endcase
      apply_settings(m, r, w);
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        // stall the output long enough to back the pipeline up into the input
        hold_req    = 1'b1;
        src_idle_on = 1'b0;
      end
      phase_len = $urandom_range(30, 70);
      repeat (phase_len) begin
        sel = $urandom_range(0, 9);
        lpres = (sel < 8);
        rpres = (sel < 7) || (sel == 8);
        send_pixel(rand_pixel(), rand_pixel(), rand_column(cur_ratio, cur_width),
                   lpres, rpres);
        random_sent++;
      end
      phase++;
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d composite pixels of %0d sent under %0d register settings",
             pixels_checked, items_sent, settings_applied);
    $display("Both modes, ratio and width extremes, random stalls and a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/icc_pkg.sv
rtl/icc_if.sv
rtl/icc_unpremul.sv
rtl/image_compare_compositor_top.sv
rtl/icc_checker.sv
dv/icc_checker.sv
dv/tb_image_compare_compositor_top.sv
